// ----- sv/bjl_pkg.sv -----
// Shared types and codes for the block-Jacobi 3x3 LDL^T preconditioner.
// No dependencies; every other file of the block imports this package.
package bjl_pkg;

   localparam int WORD_W = 32;
   localparam int NODE_W = 10;
   localparam int MODE_W = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [NODE_W-1:0]        node_type;
   typedef logic [MODE_W-1:0]        mode_type;

   localparam mode_type MODE_IDENTITY = 2'd0;
   localparam mode_type MODE_DIAG     = 2'd1;
   localparam mode_type MODE_BLOCK    = 2'd2;
   localparam mode_type MODE_RESET    = MODE_BLOCK;

   localparam logic CMD_FACTOR = 1'b0;
   localparam logic CMD_APPLY  = 1'b1;

endpackage

// ----- sv/bjl_req_if.sv -----
// Request channel: factor or apply command with block entries and vector.
// Depends on bjl_pkg for the field types.
interface bjl_req_if;
   import bjl_pkg::*;

   logic     valid;
   logic     ready;
   logic     command;
   node_type node;
   word_type a00;
   word_type a01;
   word_type a02;
   word_type a11;
   word_type a12;
   word_type a22;
   word_type v0;
   word_type v1;
   word_type v2;

   modport source (output valid, command, node, a00, a01, a02, a11, a12, a22,
                   v0, v1, v2, input ready);
   modport sink   (input valid, command, node, a00, a01, a02, a11, a12, a22,
                   v0, v1, v2, output ready);
endinterface

// ----- sv/bjl_rsp_if.sv -----
// Response channel: solved vector and pivot error flag.
// Depends on bjl_pkg for the field types.
interface bjl_rsp_if;
   import bjl_pkg::*;

   logic     valid;
   logic     ready;
   word_type z0;
   word_type z1;
   word_type z2;
   logic     pivot_error;

   modport source (output valid, z0, z1, z2, pivot_error, input ready);
   modport sink   (input valid, z0, z1, z2, pivot_error, output ready);
endinterface

// ----- sv/bjl_recip.sv -----
// Pipelined fixed-point reciprocal 2^(2*FRAC_BITS)/x, one quotient bit per stage,
// truncated toward zero and saturated to 32 bits. Carries a sideband word along.
// Depends on bjl_pkg.
module bjl_recip #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  bjl_pkg::word_type x_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output bjl_pkg::word_type recip_out,
   output logic              zero_out,
   output logic [SIDE_W-1:0] side_out
);
   import bjl_pkg::*;

   localparam int QB = 2 * FRAC_BITS + 1;
   localparam int RW = WORD_W + 1;

   logic [RW-1:0]     rem_ff  [QB+1];
   logic [RW-1:0]     rem_in  [QB+1];
   logic [QB-1:0]     quo_ff  [QB+1];
   logic [QB-1:0]     quo_in  [QB+1];
   logic [WORD_W-1:0] den_ff  [QB+1];
   logic [SIDE_W-1:0] side_ff [QB+1];
   logic [QB:0]       valid_ff;
   logic [QB:0]       neg_ff;
   logic [QB:0]       zero_ff;

   logic              valid_out_ff;
   word_type          recip_ff;
   word_type          recip_in;
   logic              zero_out_ff;
   logic [SIDE_W-1:0] side_out_ff;

   // one restoring step per stage; only the first step brings in the numerator bit
   always_comb begin
      logic [RW-1:0] trial;
      logic          ge;
      rem_in[0] = '0;
      quo_in[0] = '0;
      for (int k = 1; k <= QB; k++) begin
         trial     = {rem_ff[k-1][WORD_W-1:0], 1'(k == 1)};
         ge        = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge ? trial - {1'b0, den_ff[k-1]} : trial;
         quo_in[k] = {quo_ff[k-1][QB-2:0], ge};
      end
   end

   // sign and saturation of the final quotient
   always_comb begin
      logic [2*WORD_W-1:0] q64;
      q64 = (2*WORD_W)'(quo_ff[QB]);
      if (zero_ff[QB]) begin
         recip_in = {1'b0, {(WORD_W-1){1'b1}}};
      end else if (q64[2*WORD_W-1:WORD_W-1] != '0) begin
         recip_in = neg_ff[QB] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         recip_in = neg_ff[QB] ? -$signed(q64[WORD_W-1:0]) : $signed(q64[WORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid_out_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[QB-1:0], valid_in};
         valid_out_ff <= valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= x_in[WORD_W-1] ? ~x_in + 1'b1 : x_in;
         neg_ff     <= {neg_ff[QB-1:0], x_in[WORD_W-1]};
         zero_ff    <= {zero_ff[QB-1:0], x_in == '0};
         side_ff[0] <= side_in;
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         recip_ff    <= recip_in;
         zero_out_ff <= zero_ff[QB];
         side_out_ff <= side_ff[QB];
      end
   end

   assign valid_out = valid_out_ff;
   assign recip_out = recip_ff;
   assign zero_out  = zero_out_ff;
   assign side_out  = side_out_ff;
endmodule

// ----- sv/block_jacobi_3x3_ldlt_precond.sv -----
// Per-node 3x3 block-Jacobi preconditioner, signed fixed point with FRAC_BITS
// fraction bits. A factor transfer (command 0) computes the LDL^T factors of the
// node's symmetric block (block mode) or the reciprocal of its trace (diagonal
// mode) and stores them; an apply transfer (command 1) reads the node's factors
// and returns the solved vector; identity mode passes the vector through.
// Every transfer returns one response, in order. The block takes one transfer
// per clock cycle while the skid entry is empty. The factor path needs three
// pipelined reciprocal units, one quotient bit per stage, one after another.
// Factors live in two single-port-style RAMs of MAX_NODES rows: all traffic
// meets them at one pipeline stage, so an apply always sees every factor that
// entered ahead of it, with no interlock. A two-entry output stage (register
// plus skid) keeps input transfers flowing while one response waits. The user
// must write the preconditioner mode (mode_ff) through csr_we/csr_wdata only
// while the block is empty; the block itself does not enforce this. Mode
// three acts as identity.
module block_jacobi_3x3_ldlt_precond #(
   parameter int MAX_NODES = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [bjl_pkg::MODE_W-1:0] csr_wdata,
   bjl_req_if.sink                   req_ch,
   bjl_rsp_if.source                 rsp_ch
);
   import bjl_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   // one record travels the whole pipeline; each stage fills in its fields
   typedef struct packed {
      logic     valid;
      logic     cmd;
      logic     ok;
      logic     pivot_err;
      node_type node;
      word_type a00, a01, a02, a11, a12, a22;
      word_type v0, v1, v2;
      word_type tr;
      word_type p0, m01, m02, p1, m12, p2;
      word_type u, w, y, d1, t, e, vv, d2;
      word_type g1, g2, y0, zd1, zd2;
      word_type z1, h, k, z2, y1, y2, n, q2, y1b, q1, s;
      word_type o0, o1, o2;
   } item_type;

   typedef struct packed {
      word_type m01, m02, p1, m12, p2;
   } factor_row_type;

   typedef struct packed {
      word_type z0, z1, z2;
      logic     pivot_error;
   } out_type;

   localparam int IW = $bits(item_type);

   function automatic word_type sat_word(input logic signed [2*WORD_W-1:0] x);
      if (x > $signed((2*WORD_W)'({1'b0, {(WORD_W-1){1'b1}}}))) begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end else if (x < -$signed((2*WORD_W)'({1'b1, {(WORD_W-1){1'b0}}}))) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end
      return x[WORD_W-1:0];
   endfunction

   // floor of the product shifted down by FRAC_BITS, saturated
   function automatic word_type fx_mul(input word_type a, input word_type b);
      logic signed [2*WORD_W-1:0] p;
      p = a * b;
      return sat_word(p >>> FRAC_BITS);
   endfunction

   function automatic word_type fx_add(input word_type a, input word_type b);
      return sat_word((2*WORD_W)'(a) + (2*WORD_W)'(b));
   endfunction

   function automatic word_type fx_sub(input word_type a, input word_type b);
      return sat_word((2*WORD_W)'(a) - (2*WORD_W)'(b));
   endfunction

   mode_type mode_ff;
   logic     is_diag, is_block;
   logic     en;

   item_type f0_in, f0_ff, f1_in, f1_ff, f2_in, f2_ff, f3_in, f3_ff;
   item_type f4_in, f4_ff, f5_in, f5_ff, f6_in, f6_ff, f7_in, f7_ff;
   item_type m1_ff;
   item_type b0_in, b0_ff, b1_in, b1_ff, b2_in, b2_ff, b3_in, b3_ff, b4_in, b4_ff;
   item_type b5_in, b5_ff, b6_in, b6_ff, b7_in, b7_ff, b8_in, b8_ff, b9_in, b9_ff;

   logic          r1_valid, r2_valid, r3_valid;
   word_type      r1_val, r2_val, r3_val;
   logic          r1_zero, r2_zero, r3_zero;
   logic [IW-1:0] r1_side, r2_side, r3_side;
   word_type      r1_x;

   word_type       mem_a [MAX_NODES];
   factor_row_type mem_b [MAX_NODES];
   word_type       rd_a_ff;
   factor_row_type rd_b_ff;
   logic [AW-1:0]  mem_addr;
   logic           we_a, we_b;

   out_type  out_ff, skid_ff, out_new;
   logic     out_v_ff, skid_v_ff;
   logic     rsp_xfer, take;

   assign is_diag  = mode_ff == MODE_DIAG;
   assign is_block = mode_ff == MODE_BLOCK;

   // hold the whole pipeline only while the skid entry is occupied
   assign en           = !skid_v_ff;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // capture the transfer, range check, trace for diagonal mode
   always_comb begin
      f0_in       = '0;
      f0_in.valid = req_ch.valid;
      f0_in.cmd   = req_ch.command;
      f0_in.node  = req_ch.node;
      f0_in.ok    = 32'(req_ch.node) < 32'(MAX_NODES);
      f0_in.a00   = req_ch.a00;
      f0_in.a01   = req_ch.a01;
      f0_in.a02   = req_ch.a02;
      f0_in.a11   = req_ch.a11;
      f0_in.a12   = req_ch.a12;
      f0_in.a22   = req_ch.a22;
      f0_in.v0    = req_ch.v0;
      f0_in.v1    = req_ch.v1;
      f0_in.v2    = req_ch.v2;
      f0_in.tr    = sat_word((2*WORD_W)'(req_ch.a00) + (2*WORD_W)'(req_ch.a11)
                             + (2*WORD_W)'(req_ch.a22));
   end

   assign r1_x = is_diag ? f0_ff.tr : f0_ff.a00;

   bjl_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W(IW)) u_recip_first (
      .clock(clock), .reset(reset), .en(en),
      .valid_in(f0_ff.valid), .x_in(r1_x), .side_in(f0_ff),
      .valid_out(r1_valid), .recip_out(r1_val), .zero_out(r1_zero), .side_out(r1_side)
   );

   // first pivot and the row-zero multipliers
   always_comb begin
      f1_in       = item_type'(r1_side);
      f1_in.valid = r1_valid;
      f1_in.p0    = r1_val;
      if (f1_in.cmd == CMD_FACTOR && (is_diag || is_block)) begin
         f1_in.pivot_err = f1_in.pivot_err | r1_zero;
      end
      f1_in.m01 = fx_mul(f1_in.a01, r1_val);
      f1_in.m02 = fx_mul(f1_in.a02, r1_val);
   end

   always_comb begin
      f2_in   = f1_ff;
      f2_in.u = fx_mul(f1_ff.a01, f1_ff.m01);
      f2_in.w = fx_mul(f1_ff.a02, f1_ff.m01);
      f2_in.y = fx_mul(f1_ff.a02, f1_ff.m02);
   end

   always_comb begin
      f3_in    = f2_ff;
      f3_in.d1 = fx_sub(f2_ff.a11, f2_ff.u);
      f3_in.t  = fx_sub(f2_ff.a12, f2_ff.w);
      f3_in.e  = fx_sub(f2_ff.a22, f2_ff.y);
   end

   bjl_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W(IW)) u_recip_second (
      .clock(clock), .reset(reset), .en(en),
      .valid_in(f3_ff.valid), .x_in(f3_ff.d1), .side_in(f3_ff),
      .valid_out(r2_valid), .recip_out(r2_val), .zero_out(r2_zero), .side_out(r2_side)
   );

   always_comb begin
      f4_in       = item_type'(r2_side);
      f4_in.valid = r2_valid;
      f4_in.p1    = r2_val;
      if (f4_in.cmd == CMD_FACTOR && is_block) begin
         f4_in.pivot_err = f4_in.pivot_err | r2_zero;
      end
      f4_in.m12 = fx_mul(r2_val, f4_in.t);
   end

   always_comb begin
      f5_in    = f4_ff;
      f5_in.vv = fx_mul(f4_ff.m12, f4_ff.t);
   end

   always_comb begin
      f6_in    = f5_ff;
      f6_in.d2 = fx_sub(f5_ff.e, f5_ff.vv);
   end

   bjl_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W(IW)) u_recip_third (
      .clock(clock), .reset(reset), .en(en),
      .valid_in(f6_ff.valid), .x_in(f6_ff.d2), .side_in(f6_ff),
      .valid_out(r3_valid), .recip_out(r3_val), .zero_out(r3_zero), .side_out(r3_side)
   );

   always_comb begin
      f7_in       = item_type'(r3_side);
      f7_in.valid = r3_valid;
      f7_in.p2    = r3_val;
      if (f7_in.cmd == CMD_FACTOR && is_block) begin
         f7_in.pivot_err = f7_in.pivot_err | r3_zero;
      end
   end

   // factor store: writes and reads meet at this one stage, in transfer order
   assign mem_addr = AW'(32'(f7_ff.node));
   assign we_a     = en && f7_ff.valid && f7_ff.cmd == CMD_FACTOR && f7_ff.ok
                     && (is_diag || is_block);
   assign we_b     = we_a && is_block;

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[mem_addr] <= f7_ff.p0;
      end
      if (we_b) begin
         mem_b[mem_addr] <= '{m01: f7_ff.m01, m02: f7_ff.m02, p1: f7_ff.p1,
                              m12: f7_ff.m12, p2: f7_ff.p2};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= mem_a[mem_addr];
         rd_b_ff <= mem_b[mem_addr];
      end
   end

   // load the stored factors (zero out of range) and start the forward solve
   always_comb begin
      b0_in     = m1_ff;
      b0_in.p0  = m1_ff.ok ? rd_a_ff     : '0;
      b0_in.m01 = m1_ff.ok ? rd_b_ff.m01 : '0;
      b0_in.m02 = m1_ff.ok ? rd_b_ff.m02 : '0;
      b0_in.p1  = m1_ff.ok ? rd_b_ff.p1  : '0;
      b0_in.m12 = m1_ff.ok ? rd_b_ff.m12 : '0;
      b0_in.p2  = m1_ff.ok ? rd_b_ff.p2  : '0;
      b0_in.g1  = fx_mul(b0_in.m01, m1_ff.v0);
      b0_in.g2  = fx_mul(b0_in.m02, m1_ff.v0);
      b0_in.y0  = fx_mul(m1_ff.v0, b0_in.p0);
      b0_in.zd1 = fx_mul(m1_ff.v1, b0_in.p0);
      b0_in.zd2 = fx_mul(m1_ff.v2, b0_in.p0);
   end

   always_comb begin
      b1_in    = b0_ff;
      b1_in.z1 = fx_sub(b0_ff.v1, b0_ff.g1);
      b1_in.h  = fx_sub(b0_ff.v2, b0_ff.g2);
   end

   always_comb begin
      b2_in    = b1_ff;
      b2_in.k  = fx_mul(b1_ff.m12, b1_ff.z1);
      b2_in.y1 = fx_mul(b1_ff.z1, b1_ff.p1);
   end

   always_comb begin
      b3_in    = b2_ff;
      b3_in.z2 = fx_sub(b2_ff.h, b2_ff.k);
   end

   // diagonal scaling of the last component, then back substitution
   always_comb begin
      b4_in    = b3_ff;
      b4_in.y2 = fx_mul(b3_ff.z2, b3_ff.p2);
   end

   always_comb begin
      b5_in    = b4_ff;
      b5_in.n  = fx_mul(b4_ff.m12, b4_ff.y2);
      b5_in.q2 = fx_mul(b4_ff.m02, b4_ff.y2);
   end

   always_comb begin
      b6_in     = b5_ff;
      b6_in.y1b = fx_sub(b5_ff.y1, b5_ff.n);
   end

   always_comb begin
      b7_in    = b6_ff;
      b7_in.q1 = fx_mul(b6_ff.m01, b6_ff.y1b);
   end

   always_comb begin
      b8_in   = b7_ff;
      b8_in.s = fx_add(b7_ff.q1, b7_ff.q2);
   end

   // pick the response by command and mode
   always_comb begin
      b9_in = b8_ff;
      if (b8_ff.cmd == CMD_FACTOR) begin
         b9_in.o0 = '0;
         b9_in.o1 = '0;
         b9_in.o2 = '0;
      end else begin
         b9_in.pivot_err = 1'b0;
         if (is_block) begin
            b9_in.o0 = fx_sub(b8_ff.y0, b8_ff.s);
            b9_in.o1 = b8_ff.y1b;
            b9_in.o2 = b8_ff.y2;
         end else if (is_diag) begin
            b9_in.o0 = b8_ff.y0;
            b9_in.o1 = b8_ff.zd1;
            b9_in.o2 = b8_ff.zd2;
         end else begin
            b9_in.o0 = b8_ff.v0;
            b9_in.o1 = b8_ff.v1;
            b9_in.o2 = b8_ff.v2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff.valid <= 1'b0;
         f1_ff.valid <= 1'b0;
         f2_ff.valid <= 1'b0;
         f3_ff.valid <= 1'b0;
         f4_ff.valid <= 1'b0;
         f5_ff.valid <= 1'b0;
         f6_ff.valid <= 1'b0;
         f7_ff.valid <= 1'b0;
         m1_ff.valid <= 1'b0;
         b0_ff.valid <= 1'b0;
         b1_ff.valid <= 1'b0;
         b2_ff.valid <= 1'b0;
         b3_ff.valid <= 1'b0;
         b4_ff.valid <= 1'b0;
         b5_ff.valid <= 1'b0;
         b6_ff.valid <= 1'b0;
         b7_ff.valid <= 1'b0;
         b8_ff.valid <= 1'b0;
         b9_ff.valid <= 1'b0;
      end else if (en) begin
         f0_ff <= f0_in;
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
         f5_ff <= f5_in;
         f6_ff <= f6_in;
         f7_ff <= f7_in;
         m1_ff <= f7_ff;
         b0_ff <= b0_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
         b4_ff <= b4_in;
         b5_ff <= b5_in;
         b6_ff <= b6_in;
         b7_ff <= b7_in;
         b8_ff <= b8_in;
         b9_ff <= b9_in;
      end
   end

   // output register plus skid entry
   assign rsp_xfer = out_v_ff && rsp_ch.ready;
   assign take     = en && b9_ff.valid;
   assign out_new  = '{z0: b9_ff.o0, z1: b9_ff.o1, z2: b9_ff.o2,
                       pivot_error: b9_ff.pivot_err};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_xfer) begin
            skid_v_ff <= 1'b0;
         end
      end else if (take) begin
         if (!out_v_ff || rsp_xfer) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_xfer) begin
            out_ff <= skid_ff;
         end
      end else if (take) begin
         if (!out_v_ff || rsp_xfer) begin
            out_ff <= out_new;
         end else begin
            skid_ff <= out_new;
         end
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.z0          = out_ff.z0;
   assign rsp_ch.z1          = out_ff.z1;
   assign rsp_ch.z2          = out_ff.z2;
   assign rsp_ch.pivot_error = out_ff.pivot_error;
endmodule
